// ===== rtl/label_map_border_detector_assert.svh =====
// ----------------------------------------------------------------------------
// Label map border detector: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LABEL_MAP_BORDER_DETECTOR_ASSERT_SVH
`define LABEL_MAP_BORDER_DETECTOR_ASSERT_SVH

// condition holds at every clock edge
`define LMBD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define LMBD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the antecedent
`define LMBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Label map border detector: package
// Result type, result queue sizing and configuration register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lmbd_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int IMG_W_BITS = 12;
	localparam int IMG_H_BITS = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

	// result fields
	localparam int POS_X_W = 11;
	localparam int POS_Y_W = 12;

	typedef struct packed {
		logic [POS_X_W-1:0] pos_x;
		logic [POS_Y_W-1:0] pos_y;
		logic               is_border;
		logic               frame_done;
		logic               last_of_item;
	} res_t;

	// up to two results enter the queue per cycle, the delayed one first
	typedef struct packed {
		logic valid0;
		logic valid1;
		res_t item0;
		res_t item1;
	} res_push_t;

	// result queue
	localparam int RQ_DEPTH = 8;
	localparam int RQ_PW    = 3;
	localparam int RQ_LVL_W = RQ_PW + 1;

	// highest fill level at which a new pixel is still taken
	localparam logic [RQ_LVL_W-1:0] RQ_ROOM_BUSY = RQ_LVL_W'(RQ_DEPTH - 4);
	localparam logic [RQ_LVL_W-1:0] RQ_ROOM_IDLE = RQ_LVL_W'(RQ_DEPTH - 2);

endpackage

`default_nettype wire

// ===== rtl/lmbd_res_queue.sv =====
// ----------------------------------------------------------------------------
// Label map border detector: result queue
// Small register FIFO taking up to two results per cycle, one out per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "label_map_border_detector_assert.svh"

module lmbd_res_queue (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lmbd_pkg::res_push_t            push,
	output logic [lmbd_pkg::RQ_LVL_W-1:0]       level,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output lmbd_pkg::res_t                      out_item
);

	localparam logic [lmbd_pkg::RQ_LVL_W:0] MAX_LEVEL =
		(lmbd_pkg::RQ_LVL_W + 1)'(lmbd_pkg::RQ_DEPTH);

	lmbd_pkg::res_t                  entry_q [lmbd_pkg::RQ_DEPTH];
	logic [lmbd_pkg::RQ_PW-1:0]      wr_ptr_q;
	logic [lmbd_pkg::RQ_PW-1:0]      rd_ptr_q;
	logic [lmbd_pkg::RQ_LVL_W-1:0]   level_q;
	logic [lmbd_pkg::RQ_LVL_W:0]     level_next;
	logic [1:0]                      n_push;
	logic                            pop;

	assign level     = level_q;
	assign out_valid = (level_q != '0);
	assign out_item  = entry_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	// fill level bookkeeping
	always_comb begin
		n_push     = 2'({1'b0, push.valid0}) + 2'({1'b0, push.valid1});
		level_next = (lmbd_pkg::RQ_LVL_W + 1)'(level_q)
			+ (lmbd_pkg::RQ_LVL_W + 1)'(n_push)
			- (lmbd_pkg::RQ_LVL_W + 1)'(pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lmbd_pkg::RQ_PW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lmbd_pkg::RQ_PW'(1);
			end
			level_q <= level_next[lmbd_pkg::RQ_LVL_W-1:0];
		end
	end

	// storage; a lone push always lands at the write pointer
	always_ff @(posedge clk) begin
		if (push.valid0 || push.valid1) begin
			entry_q[wr_ptr_q] <= push.valid0 ? push.item0 : push.item1;
		end
		if (push.valid0 && push.valid1) begin
			entry_q[wr_ptr_q + lmbd_pkg::RQ_PW'(1)] <= push.item1;
		end
	end

	`LMBD_ASSERT_ALWAYS(a_rq_no_overflow, level_next <= MAX_LEVEL, "result queue overflow")
	`LMBD_ASSERT_NEXT(a_rq_hold_valid, out_valid && out_stall, out_valid, "stalled result dropped")
	`LMBD_ASSERT_NEXT(a_rq_hold_item, out_valid && out_stall, $stable(out_item), "stalled result changed")

endmodule

`default_nettype wire

// ===== rtl/label_map_border_detector.sv =====
// A result is registered in stage 1 and held in the result queue before it is offered; an
// interior pixel waits for its lower-right neighbor. Throughput: one pixel per cycle while
// the result queue has room, set by the single read and write port of the line memory.
// On the last row each pixel from the third column on causes two results, so intake follows
// the output at one result per cycle there; a small result queue absorbs row-end bursts.
// Reset: position counters clear, dimensions become 640 x 480; line memory is not cleared.
// ----------------------------------------------------------------------------
// Label map border detector
// Marks each pixel of a label raster as border when it sits on an image edge
// or any 8-neighbor carries a different label. Two line stores in one memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "label_map_border_detector_assert.svh"

module label_map_border_detector #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	parameter int LABEL_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [31:0]                       pixel_label,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [lmbd_pkg::POS_X_W-1:0]           pos_x,
	output logic [lmbd_pkg::POS_Y_W-1:0]           pos_y,
	output logic                                   is_border,
	output logic                                   frame_done,
	output logic                                   last_of_item,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lmbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lmbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int LB = LABEL_BITS;
	localparam int W_RST_LAST = ((640 > MAX_WIDTH) ? MAX_WIDTH : 640) - 1;
	localparam int H_RST_LAST = ((480 > MAX_HEIGHT) ? MAX_HEIGHT : 480) - 1;

	// configuration and position state
	logic [XW-1:0] wlast_q;
	logic [YW-1:0] hlast_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;

	logic [31:0]   cfg_w;
	logic [31:0]   cfg_h;
	logic [XW-1:0] wlast_new;
	logic [YW-1:0] hlast_new;
	logic          cfg_wr;
	logic          cfg_hit;
	logic          in_acc;

	// stage 1
	logic          valid_s1;
	logic [XW-1:0] x_s1;
	logic [YW-1:0] y_s1;
	logic [LB-1:0] p_s1;
	logic          interior_s1;
	logic          edge_s1;
	logic          done_s1;

	// line memory: {upper, lower} per column
	logic [2*LB-1:0] line_mem [MAX_WIDTH];
	logic [2*LB-1:0] rd_q;
	logic [LB-1:0]   up_lbl;
	logic [LB-1:0]   lo_lbl;

	logic [LB-1:0]   win_q [6];
	logic            diff;

	lmbd_pkg::res_push_t              push;
	lmbd_pkg::res_t                   out_item;
	logic [lmbd_pkg::RQ_LVL_W-1:0]    level;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_wr && (cfg_index == lmbd_pkg::CFG_IMAGE_WIDTH ||
		cfg_index == lmbd_pkg::CFG_IMAGE_HEIGHT);

	// hold intake while the queue may lack room for this and the in-flight pixel
	assign in_stall = valid_s1 ? (level > lmbd_pkg::RQ_ROOM_BUSY)
		: (level > lmbd_pkg::RQ_ROOM_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// clamp written dimensions, keep them as last index
	always_comb begin
		cfg_w = 32'(cfg_data[lmbd_pkg::IMG_W_BITS-1:0]);
		cfg_h = 32'(cfg_data[lmbd_pkg::IMG_H_BITS-1:0]);
		if (cfg_w < 32'd3) begin
			wlast_new = XW'(2);
		end else if (cfg_w > 32'(MAX_WIDTH)) begin
			wlast_new = XW'(MAX_WIDTH - 1);
		end else begin
			wlast_new = XW'(cfg_w - 32'd1);
		end
		if (cfg_h < 32'd3) begin
			hlast_new = YW'(2);
		end else if (cfg_h > 32'(MAX_HEIGHT)) begin
			hlast_new = YW'(MAX_HEIGHT - 1);
		end else begin
			hlast_new = YW'(cfg_h - 32'd1);
		end
	end

	// dimensions and raster position; a dimension register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= XW'(W_RST_LAST);
			hlast_q <= YW'(H_RST_LAST);
			x_q     <= '0;
			y_q     <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == lmbd_pkg::CFG_IMAGE_WIDTH) begin
				wlast_q <= wlast_new;
			end else begin
				hlast_q <= hlast_new;
			end
			x_q <= '0;
			y_q <= '0;
		end else if (in_acc) begin
			if (x_q == wlast_q) begin
				x_q <= '0;
				y_q <= (y_q == hlast_q) ? '0 : y_q + YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	// stage 1 payload and position flags
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1        <= x_q;
			y_s1        <= y_q;
			p_s1        <= pixel_label[LB-1:0];
			interior_s1 <= (x_q >= XW'(2)) && (y_q >= YW'(2));
			edge_s1     <= (x_q == '0) || (x_q == wlast_q) || (y_q == '0) ||
				(y_q == hlast_q);
			done_s1     <= (x_q == wlast_q) && (y_q == hlast_q);
		end
	end

	// line memory: read at intake, write back shifted column in stage 1
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q <= line_mem[x_q];
		end
		if (valid_s1) begin
			line_mem[x_s1] <= {lo_lbl, p_s1};
		end
	end

	assign up_lbl = rd_q[2*LB-1:LB];
	assign lo_lbl = rd_q[LB-1:0];

	// neighborhood compare around the center at column x-1, row y-1
	always_comb begin
		diff = (up_lbl != win_q[1]) || (lo_lbl != win_q[1]) || (p_s1 != win_q[1]) ||
			(win_q[0] != win_q[1]) || (win_q[2] != win_q[1]) ||
			(win_q[3] != win_q[1]) || (win_q[4] != win_q[1]) ||
			(win_q[5] != win_q[1]);
	end

	// 3x3 window shift: two older columns
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= up_lbl;
			win_q[1] <= lo_lbl;
			win_q[2] <= p_s1;
		end
	end

	// results: delayed interior pixel first, then arriving edge pixel
	always_comb begin
		push.valid0              = valid_s1 && interior_s1;
		push.valid1              = valid_s1 && edge_s1;
		push.item0.pos_x         = lmbd_pkg::POS_X_W'(x_s1 - XW'(1));
		push.item0.pos_y         = lmbd_pkg::POS_Y_W'(y_s1 - YW'(1));
		push.item0.is_border     = diff;
		push.item0.frame_done    = 1'b0;
		push.item0.last_of_item  = !edge_s1;
		push.item1.pos_x         = lmbd_pkg::POS_X_W'(x_s1);
		push.item1.pos_y         = lmbd_pkg::POS_Y_W'(y_s1);
		push.item1.is_border     = 1'b1;
		push.item1.frame_done    = done_s1;
		push.item1.last_of_item  = 1'b1;
	end

	lmbd_res_queue u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.level     (level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	assign pos_x        = out_item.pos_x;
	assign pos_y        = out_item.pos_y;
	assign is_border    = out_item.is_border;
	assign frame_done   = out_item.frame_done;
	assign last_of_item = out_item.last_of_item;

	`LMBD_ASSERT_IMPLY(a_no_rw_collision, in_acc && valid_s1, x_q != x_s1, "column clash")
	`LMBD_ASSERT_ALWAYS(a_col_in_range, x_q <= wlast_q, "column counter beyond row end")
	`LMBD_ASSERT_IMPLY(a_done_edge, out_valid & frame_done, is_border & last_of_item, "bad frame end")
	`LMBD_ASSERT_NEXT(a_cfg_restart, cfg_hit, x_q == '0 && y_q == '0, "frame not restarted")

endmodule

`default_nettype wire

// ===== bench/label_map_border_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label map border detector: testbench
// Streams label rasters through the detector at several frame geometries and
// compares every reported pixel with a cycle-free model of the 3x3 window.
// ----------------------------------------------------------------------------

module label_map_border_detector_tb;

	localparam int MAX_W = 2048;
	localparam int MAX_H = 4096;

	// register indexes that map to nothing
	localparam logic [lmbd_pkg::CFG_IDX_W-1:0] CFG_NO_REG_LO = 8'd2;
	localparam logic [lmbd_pkg::CFG_IDX_W-1:0] CFG_NO_REG_HI = 8'hFF;

	// output hold-offs that back the result queue up into the pixel input
	localparam int HOLD_AT_A   = 40;
	localparam int HOLD_AT_B   = 300;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic [31:0]                          pixel_label = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [lmbd_pkg::POS_X_W-1:0]         pos_x;
	logic [lmbd_pkg::POS_Y_W-1:0]         pos_y;
	logic                                 is_border;
	logic                                 frame_done;
	logic                                 last_of_item;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [lmbd_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [lmbd_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	label_map_border_detector #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H),
		.LABEL_BITS(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_label(pixel_label),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.is_border(is_border),
		.frame_done(frame_done),
		.last_of_item(last_of_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// shadow state of the detector
	logic [lmbd_pkg::IMG_W_BITS-1:0] width_reg = 12'd640;
	logic [lmbd_pkg::IMG_H_BITS-1:0] height_reg = 13'd480;
	logic [31:0] row_store_far [MAX_W];
	logic [31:0] row_store_near [MAX_W];
	logic [31:0] win [6];
	int unsigned col_next = 0;
	int unsigned row_next = 0;

	logic [31:0]    pixels_to_send [$];
	lmbd_pkg::res_t reports_due [$];

	int unsigned pix_queued = 0;
	int unsigned pix_accepted = 0;
	int unsigned reports_checked = 0;
	int unsigned borders_seen = 0;
	int unsigned frames_seen = 0;
	int unsigned errors = 0;
	logic        pix_taken = 1'b0;

	int tx_gap = 0, tx_burst = 0;
	int rx_gap = 0, rx_burst = 0;
	int hold_left = 0, holds_done = 0;

	initial begin
		for (int i = 0; i < MAX_W; i++) begin
			row_store_far[i] = '0;
			row_store_near[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			win[i] = '0;
	end

	function automatic int unsigned eff_dim(input int unsigned v, input int unsigned top);
		if (v < 3) return 3;
		if (v > top) return top;
		return v;
	endfunction

	// idle length: mostly short, a few long, with occasional gap-free bursts
	function automatic int idle_len(inout int burst_left);
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (pick < 50) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// one pixel into the window; expected reports go onto reports_due
	task automatic mark_pixel(input logic [31:0] lbl);
		int unsigned w, h, x, y;
		logic [31:0] above2, above1, ctr;
		logic on_rim;
		lmbd_pkg::res_t r;
		w = eff_dim(32'(width_reg), MAX_W);
		h = eff_dim(32'(height_reg), MAX_H);
		x = (col_next >= w) ? 0 : col_next;
		y = (row_next >= h) ? 0 : row_next;
		on_rim = (x == 0 || x == w - 1 || y == 0 || y == h - 1);

		above2 = row_store_far[x];
		above1 = row_store_near[x];
		row_store_far[x] = above1;
		row_store_near[x] = lbl;

		// interior pixel up-left of this one is now complete
		if (x >= 2 && y >= 2) begin
			ctr = win[1];
			r.pos_x = lmbd_pkg::POS_X_W'(x - 1);
			r.pos_y = lmbd_pkg::POS_Y_W'(y - 1);
			r.is_border = (above2 != ctr) || (above1 != ctr) || (lbl != ctr) ||
				(win[0] != ctr) || (win[2] != ctr) || (win[3] != ctr) ||
				(win[4] != ctr) || (win[5] != ctr);
			r.frame_done = 1'b0;
			r.last_of_item = !on_rim;
			reports_due = {reports_due, r};
		end

		win[3] = win[0];
		win[4] = win[1];
		win[5] = win[2];
		win[0] = above2;
		win[1] = above1;
		win[2] = lbl;

		// rim pixels are reported on arrival
		if (on_rim) begin
			r.pos_x = lmbd_pkg::POS_X_W'(x);
			r.pos_y = lmbd_pkg::POS_Y_W'(y);
			r.is_border = 1'b1;
			r.frame_done = (x == w - 1 && y == h - 1);
			r.last_of_item = 1'b1;
			reports_due = {reports_due, r};
		end

		if (x + 1 >= w) begin
			col_next = 0;
			row_next = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			col_next = x + 1;
			row_next = y;
		end
	endtask

	task automatic apply_reg(input logic [lmbd_pkg::CFG_IDX_W-1:0] idx,
		input logic [lmbd_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			lmbd_pkg::CFG_IMAGE_WIDTH: begin
				width_reg = data[lmbd_pkg::IMG_W_BITS-1:0];
				col_next = 0;
				row_next = 0;
			end
			lmbd_pkg::CFG_IMAGE_HEIGHT: begin
				height_reg = data[lmbd_pkg::IMG_H_BITS-1:0];
				col_next = 0;
				row_next = 0;
			end
			default: ;
		endcase
	endtask

	// monitor: check results, then predict for the pixel and register transfers
	always @(posedge clk) begin
		lmbd_pkg::res_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.pos_x = pos_x;
				got.pos_y = pos_y;
				got.is_border = is_border;
				got.frame_done = frame_done;
				got.last_of_item = last_of_item;
				if (reports_due.size() == 0) begin
					flag_error($sformatf("result with none expected: x=%0d y=%0d border=%b",
						pos_x, pos_y, is_border));
				end else begin
					want = reports_due.pop_front();
					reports_checked++;
					if (want.is_border) borders_seen++;
					if (want.frame_done) frames_seen++;
					if (got !== want)
						flag_error($sformatf(
							"exp x=%0d y=%0d b=%b fd=%b last=%b, got x=%0d y=%0d b=%b fd=%b last=%b",
							want.pos_x, want.pos_y, want.is_border, want.frame_done,
							want.last_of_item, got.pos_x, got.pos_y, got.is_border,
							got.frame_done, got.last_of_item));
				end
			end
			if (in_valid && !in_stall) begin
				mark_pixel(pixel_label);
				pix_accepted++;
				pix_taken = 1'b1;
			end
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
		end
	end

	// driver: next pixel once the current one is transferred
	always @(negedge clk) begin
		if (arst_n && (!in_valid || pix_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (pixels_to_send.size() != 0) begin
				in_valid <= 1'b1;
				pixel_label <= pixels_to_send.pop_front();
				tx_gap = idle_len(tx_burst);
			end else begin
				in_valid <= 1'b0;
			end
		end
		pix_taken = 1'b0;
	end

	// result side stalls, with two long hold-offs
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_done < 2 &&
			pix_accepted >= ((holds_done == 0) ? HOLD_AT_A : HOLD_AT_B)) begin
			hold_left = HOLD_CYCLES - 1;
			holds_done++;
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			rx_gap = idle_len(rx_burst);
		end
	end

	task automatic offer(input logic [31:0] lbl);
		pixels_to_send = {pixels_to_send, lbl};
		pix_queued++;
	endtask

	// all pixels transferred, all results in, pipeline drained
	task automatic wait_idle();
		do @(negedge clk);
		while (pix_accepted != pix_queued || reports_due.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [lmbd_pkg::CFG_IDX_W-1:0] idx,
		input logic [lmbd_pkg::CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// blocky regions from a small palette, with sparse noise
	task automatic queue_frame(input int unsigned w, input int unsigned h,
		input int unsigned count);
		int unsigned x, y, bw, bh;
		logic [31:0] pal [3];
		bw = $urandom_range(1, 6);
		bh = $urandom_range(1, 6);
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 3))
				0: pal[k] = '0;
				1: pal[k] = '1;
				default: pal[k] = $urandom();
			endcase
		end
		for (int unsigned i = 0; i < count; i++) begin
			x = i % w;
			y = (i / w) % h;
			if ($urandom_range(0, 15) == 0)
				offer($urandom());
			else
				offer(pal[(x / bw + y / bh) % 3]);
		end
	endtask

	// stimulus
	initial begin
		int unsigned rand_items, w_eff, h_eff, count;
		int pick;
		logic [lmbd_pkg::CFG_DATA_W-1:0] cur_w, cur_h;
		rand_items = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// power-on geometry: start of the first row at 640 wide
		queue_frame(640, 480, 60);

		// smallest frame, uniform: lone interior pixel is not a border
		write_reg(lmbd_pkg::CFG_IMAGE_WIDTH, 16'd3);
		write_reg(lmbd_pkg::CFG_IMAGE_HEIGHT, 16'd3);
		repeat (9) offer('1);
		// odd label in the last corner marks the center
		for (int i = 0; i < 9; i++)
			offer((i == 8) ? 32'h0000_0001 : 32'h0000_0000);
		// writes to unused indexes must not restart the frame
		for (int i = 0; i < 4; i++)
			offer($urandom());
		write_reg(CFG_NO_REG_LO, 16'hFFFF);
		write_reg(CFG_NO_REG_HI, 16'h0003);
		@(posedge clk);
		for (int i = 0; i < 5; i++)
			offer($urandom());
		cur_w = 16'd3;
		cur_h = 16'd3;

		// small random geometries, full and cut-off frames
		while (rand_items < 240) begin
			pick = $urandom_range(0, 2);
			if (pick != 1) begin
				case ($urandom_range(0, 7))
					0: cur_w = 16'($urandom_range(0, 2));
					1: cur_w = 16'(32'hF000 + $urandom_range(3, 12));
					default: cur_w = 16'($urandom_range(3, 12));
				endcase
				write_reg(lmbd_pkg::CFG_IMAGE_WIDTH, cur_w);
			end
			if (pick != 0) begin
				case ($urandom_range(0, 7))
					0: cur_h = 16'($urandom_range(0, 2));
					1: cur_h = 16'(32'hE000 + $urandom_range(3, 9));
					default: cur_h = 16'($urandom_range(3, 9));
				endcase
				write_reg(lmbd_pkg::CFG_IMAGE_HEIGHT, cur_h);
			end
			w_eff = eff_dim(32'(cur_w[lmbd_pkg::IMG_W_BITS-1:0]), MAX_W);
			h_eff = eff_dim(32'(cur_h[lmbd_pkg::IMG_H_BITS-1:0]), MAX_H);
			count = $urandom_range(1, 2) * w_eff * h_eff;
			if ($urandom_range(0, 2) == 0)
				count += $urandom_range(1, w_eff * h_eff - 1);
			queue_frame(w_eff, h_eff, count);
			rand_items += count;
		end

		// widest frame, then width clamped from above; first row only
		write_reg(lmbd_pkg::CFG_IMAGE_WIDTH, 16'd2048);
		write_reg(lmbd_pkg::CFG_IMAGE_HEIGHT, 16'd3);
		queue_frame(MAX_W, 3, 30);
		write_reg(lmbd_pkg::CFG_IMAGE_WIDTH, 16'hFFFF);
		write_reg(lmbd_pkg::CFG_IMAGE_HEIGHT, 16'd0);
		queue_frame(MAX_W, 3, 30);

		// tallest frame, then height clamped from above; first rows only
		write_reg(lmbd_pkg::CFG_IMAGE_WIDTH, 16'd3);
		write_reg(lmbd_pkg::CFG_IMAGE_HEIGHT, 16'd4096);
		queue_frame(3, MAX_H, 30);
		write_reg(lmbd_pkg::CFG_IMAGE_WIDTH, 16'd1);
		write_reg(lmbd_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
		queue_frame(3, MAX_H, 30);

		wait_idle();
		repeat (20) @(negedge clk);
		$display("Run: %0d pixels, %0d results checked, %0d borders, %0d frames finished",
			pix_accepted, reports_checked, borders_seen, frames_seen);
		$display("Geometries from 3x3 to widest and tallest, clamped sizes, frame wrap, unused writes");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
